### rtl/nntc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nntc_pkg;

   // Default for the largest vertex count the matrix can hold.
   localparam int MaxVerticesDef = 16;

   // Fixed field widths of the streams.
   localparam int FieldW   = 5;
   localparam int CostW    = 10;
   localparam int SumW     = 16;
   localparam int VcW      = 5;
   localparam int ReqDataW = 32;
   localparam int RspDataW = 16;

   // A cost at or above this value is never taken as a step.
   localparam logic [CostW-1:0] NoEdge = 10'd999;

   // Vertex count after reset.
   localparam logic [VcW-1:0] VertexCountRst = 5'd4;

   // Command codes carried in the request tuser.
   localparam logic CmdLoad = 1'b0;
   localparam logic CmdRun  = 1'b1;

   // Operations of the shared compare and add unit.
   typedef enum logic [2:0] {
      OP_IDLE,
      OP_INIT,
      OP_CMP,
      OP_ADD_BEST,
      OP_ADD_DATA
   } step_op_type;

   // Sequencer to step unit.
   typedef struct packed {
      step_op_type op;
      logic        cand_free;
   } step_ctrl_type;

   // Step unit back to sequencer.
   typedef struct packed {
      logic            found;
      logic [SumW-1:0] sum;
   } step_sts_type;

endpackage

`default_nettype wire

### rtl/nntc_cost_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module nntc_cost_ram
   import nntc_pkg::*;
#(
   parameter int AddrW = 8
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire logic [CostW-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AddrW-1:0] rd_addr,
   output logic      [CostW-1:0] rd_data
);

   localparam int Depth = 2 ** AddrW;

   logic [CostW-1:0] mem_ff [Depth];
   logic [CostW-1:0] rd_data_ff;

   // One write port and one registered read port; contents are undefined until written.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/nntc_step_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module nntc_step_unit
   import nntc_pkg::*;
#(
   parameter int IdxW = 4
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire step_ctrl_type ctrl,
   input  wire logic [IdxW-1:0]  cand_idx,
   input  wire logic [CostW-1:0] rd_data,
   output step_sts_type       sts,
   output logic [IdxW-1:0]    pick
);

   logic [CostW-1:0] best_ff, best_in;
   logic [IdxW-1:0]  pick_ff, pick_in;
   logic             found_ff, found_in;
   logic [SumW-1:0]  sum_ff, sum_in;

   logic             better;
   logic [CostW-1:0] addend;
   logic [SumW:0]    sum_wide;
   logic [SumW-1:0]  sum_sat;

   // Candidate test: unvisited, a real edge, and strictly cheaper than the best so far.
   assign better = ctrl.cand_free && (rd_data != '0) && (rd_data < best_ff);

   // The one adder, saturating at the top of the sum range.
   assign addend   = (ctrl.op == OP_ADD_BEST) ? best_ff : rd_data;
   assign sum_wide = {1'b0, sum_ff} + (SumW + 1)'(addend);
   assign sum_sat  = sum_wide[SumW] ? '1 : sum_wide[SumW-1:0];

   always_comb begin
      best_in  = best_ff;
      pick_in  = pick_ff;
      found_in = found_ff;
      sum_in   = sum_ff;
      unique case (ctrl.op)
         OP_IDLE: begin
         end
         OP_INIT: begin
            sum_in   = '0;
            best_in  = NoEdge;
            found_in = 1'b0;
         end
         OP_CMP: begin
            if (better) begin
               best_in  = rd_data;
               pick_in  = cand_idx;
               found_in = 1'b1;
            end
         end
         OP_ADD_BEST: begin
            // Take the chosen edge and prime the search for the next step.
            sum_in   = sum_sat;
            best_in  = NoEdge;
            found_in = 1'b0;
         end
         OP_ADD_DATA: begin
            sum_in = sum_sat;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
         sum_ff   <= '0;
      end else begin
         found_ff <= found_in;
         sum_ff   <= sum_in;
      end
      best_ff <= best_in;
      pick_ff <= pick_in;
   end

   assign sts.found = found_ff;
   assign sts.sum   = sum_ff;
   assign pick      = pick_ff;

endmodule

`default_nettype wire

### rtl/nearest_neighbor_tsp_tour_cost.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  tdata                                     tuser
// req_      in         row[4:0] col[9:5] cost[19:10] start[24:20] cmd
// rsp_      out        tour_cost[15:0]                           stuck
// csr_      in         vertex_count write, no read-back          -
//
// A load beat is accepted only in idle. A run is paced by the single read port of the
// cost matrix, which is scanned one entry a cycle along the current row for each step.
// Reset clears the sequencer, visited marks and running sum; the cost matrix is
// undefined until loaded. A result waits in the output register; loads are still
// taken meanwhile, and a following run holds its own result until the register frees.

module nearest_neighbor_tsp_tour_cost
   import nntc_pkg::*;
#(
   parameter int MAX_VERTICES = MaxVerticesDef
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // Request stream
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [ReqDataW-1:0] req_tdata,   // row, col, cost, start_vertex
   input  wire logic                req_tuser,   // cmd
   // Result stream
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic      [RspDataW-1:0] rsp_tdata,   // tour_cost
   output logic                     rsp_tuser,   // stuck
   // Configuration
   input  wire logic                csr_we,
   input  wire logic [VcW-1:0]      csr_wdata
);

   localparam int IdxW  = $clog2(MAX_VERTICES);
   localparam int CntW  = $clog2(MAX_VERTICES + 1);
   localparam int AddrW = 2 * IdxW;

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_SCAN    = 7'b0000010,
      ST_LAST    = 7'b0000100,
      ST_MOVE    = 7'b0001000,
      ST_RET_RD  = 7'b0010000,
      ST_RET_ADD = 7'b0100000,
      ST_EMIT    = 7'b1000000
   } state_type;

   state_type             state_ff, state_in;
   logic [VcW-1:0]        vertex_count_ff, vertex_count_in;
   logic [MAX_VERTICES-1:0] visited_ff, visited_in;
   logic [IdxW-1:0]       cur_ff, cur_in;
   logic [IdxW-1:0]       home_ff, home_in;
   logic [IdxW-1:0]       j_ff, j_in;
   logic [IdxW-1:0]       jd_ff, jd_in;
   logic                  rdv_ff, rdv_in;
   logic [CntW-1:0]       steps_ff, steps_in;
   logic                  stuck_ff, stuck_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SumW-1:0]       rsp_cost_ff, rsp_cost_in;
   logic                  rsp_stuck_ff, rsp_stuck_in;

   logic [FieldW-1:0] req_row, req_col, req_start;
   logic [CostW-1:0]  req_cost;
   logic              req_fire;
   logic              load_ok, start_ok;
   logic [CntW-1:0]   n_used, n_last;
   logic [IdxW-1:0]   home_idx;

   logic              wr_en, rd_en;
   logic [AddrW-1:0]  wr_addr, rd_addr;
   logic [CostW-1:0]  rd_data;

   step_ctrl_type     ctrl;
   step_sts_type      sts;
   logic [IdxW-1:0]   pick;

   // Unpack the request beat.
   assign req_row   = req_tdata[4:0];
   assign req_col   = req_tdata[9:5];
   assign req_cost  = req_tdata[19:10];
   assign req_start = req_tdata[24:20];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // Vertex count saturated into the supported range.
   always_comb begin
      if (vertex_count_ff < 5'd2) begin
         n_used = CntW'(2);
      end else if (32'(vertex_count_ff) > MAX_VERTICES) begin
         n_used = CntW'(MAX_VERTICES);
      end else begin
         n_used = CntW'(vertex_count_ff);
      end
   end
   assign n_last = n_used - CntW'(1);

   assign load_ok  = (req_row != '0) && (32'(req_row) <= MAX_VERTICES) &&
                     (req_col != '0) && (32'(req_col) <= MAX_VERTICES);
   assign start_ok = (req_start != '0) && (32'(req_start) <= 32'(n_used));
   assign home_idx = IdxW'(req_start - 5'd1);

   // Matrix access: loads write in idle, the scan and the return edge read.
   assign wr_en   = req_fire && (req_tuser == CmdLoad) && load_ok;
   assign wr_addr = {IdxW'(req_row - 5'd1), IdxW'(req_col - 5'd1)};
   assign rd_en   = (state_ff == ST_SCAN) || (state_ff == ST_RET_RD);
   assign rd_addr = (state_ff == ST_SCAN) ? {cur_ff, j_ff} : {cur_ff, home_ff};

   nntc_cost_ram #(
      .AddrW (AddrW)
   ) u_cost_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_cost),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Operation for the shared unit in this cycle.
   always_comb begin
      ctrl.op        = OP_IDLE;
      ctrl.cand_free = !visited_ff[jd_ff];
      priority if (req_fire && (req_tuser == CmdRun)) begin
         ctrl.op = OP_INIT;
      end else if (rdv_ff) begin
         ctrl.op = OP_CMP;
      end else if ((state_ff == ST_MOVE) && sts.found) begin
         ctrl.op = OP_ADD_BEST;
      end else if (state_ff == ST_RET_ADD) begin
         ctrl.op = OP_ADD_DATA;
      end
   end

   nntc_step_unit #(
      .IdxW (IdxW)
   ) u_step_unit (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .cand_idx (jd_ff),
      .rd_data  (rd_data),
      .sts      (sts),
      .pick     (pick)
   );

   // Sequencer.
   always_comb begin
      state_in        = state_ff;
      vertex_count_in = csr_we ? csr_wdata : vertex_count_ff;
      visited_in      = visited_ff;
      cur_in          = cur_ff;
      home_in         = home_ff;
      j_in            = j_ff;
      jd_in           = jd_ff;
      rdv_in          = 1'b0;
      steps_in        = steps_ff;
      stuck_in        = stuck_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_cost_in     = rsp_cost_ff;
      rsp_stuck_in    = rsp_stuck_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_tuser == CmdRun)) begin
               if (start_ok) begin
                  visited_in           = '0;
                  visited_in[home_idx] = 1'b1;
                  cur_in               = home_idx;
                  home_in              = home_idx;
                  j_in                 = '0;
                  steps_in             = '0;
                  stuck_in             = 1'b0;
                  state_in             = ST_SCAN;
               end else begin
                  stuck_in = 1'b1;
                  state_in = ST_EMIT;
               end
            end
         end
         ST_SCAN: begin
            // Issue one row entry a cycle; its data is compared in the following cycle.
            rdv_in = 1'b1;
            jd_in  = j_ff;
            if (CntW'(j_ff) == n_last) begin
               state_in = ST_LAST;
            end else begin
               j_in = j_ff + IdxW'(1);
            end
         end
         ST_LAST: begin
            state_in = ST_MOVE;
         end
         ST_MOVE: begin
            if (!sts.found) begin
               stuck_in = 1'b1;
               state_in = ST_EMIT;
            end else begin
               visited_in[pick] = 1'b1;
               cur_in           = pick;
               steps_in         = steps_ff + CntW'(1);
               j_in             = '0;
               if (steps_ff + CntW'(1) == n_last) begin
                  state_in = ST_RET_RD;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_RET_RD: begin
            state_in = ST_RET_ADD;
         end
         ST_RET_ADD: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_cost_in  = sts.sum;
               rsp_stuck_in = stuck_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         vertex_count_ff <= VertexCountRst;
         visited_ff      <= '0;
         cur_ff          <= '0;
         j_ff            <= '0;
         rdv_ff          <= 1'b0;
         steps_ff        <= '0;
         stuck_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         vertex_count_ff <= vertex_count_in;
         visited_ff      <= visited_in;
         cur_ff          <= cur_in;
         j_ff            <= j_in;
         rdv_ff          <= rdv_in;
         steps_ff        <= steps_in;
         stuck_ff        <= stuck_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      home_ff      <= home_in;
      jd_ff        <= jd_in;
      rsp_cost_ff  <= rsp_cost_in;
      rsp_stuck_ff <= rsp_stuck_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_cost_ff;
   assign rsp_tuser  = rsp_stuck_ff;

   // The start vertex stays marked for the whole tour.
   a_home_marked : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> visited_ff[home_ff])
      else $error("start vertex lost its visited mark");

   // One mark per completed step plus the start vertex.
   a_mark_count : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> ($countones(visited_ff) == int'(steps_ff) + 1))
      else $error("visited marks disagree with step count");

   // A chosen vertex was never visited before.
   a_pick_fresh : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_MOVE) && sts.found) |-> !visited_ff[pick])
      else $error("step picked a visited vertex");

   // A result only appears from the emit state.
   a_emit_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_EMIT))
      else $error("result raised outside emit state");

endmodule

`default_nettype wire
